@@ rtl/phase_sample_frame_reassembler_core_assert.svh @@
// Assertion macros for the phase sample frame reassembler.
// Included by the top level; no other dependencies.
`ifndef PHASE_SAMPLE_FRAME_REASSEMBLER_CORE_ASSERT_SVH
`define PHASE_SAMPLE_FRAME_REASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("psfr: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("psfr: next-cycle check failed");

`endif

@@ rtl/psfr_pkg.sv @@
// Shared types and constants for the phase sample frame reassembler.
// No dependencies.
package psfr_pkg;

	// default sizing, handed to the top-level parameters
	localparam int SAMPLE_DEPTH_DEF     = 1024;
	localparam int VALUES_PER_FRAME_DEF = 31;
	localparam int MAX_FRAMES_DEF       = 32;

	// fixed field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// frame layout
	localparam logic [15:0] SAMPLE_OFFSET = 16'd2048;
	localparam logic [6:0]  DATA_FIRST    = 7'd2;
	localparam logic [6:0]  POS_LIMIT     = 7'd127;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_ID_FIRST    = 3'd0,
		CFG_PHASE_ID_SECOND   = 3'd1,
		CFG_PHASE_ID_THIRD    = 3'd2,
		CFG_FRAMES_PER_PHASE  = 3'd3,
		CFG_SAMPLES_PER_PHASE = 3'd4
	} cfg_idx_t;

	// input item modes
	typedef enum logic [1:0] {
		MODE_FRAME   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2
	} mode_t;

	// per-frame verdict, also reported as frame status
	typedef enum logic [1:0] {
		STATUS_NONE    = 2'd0,
		STATUS_STORED  = 2'd1,
		STATUS_BAD_NUM = 2'd2,
		STATUS_UNKNOWN = 2'd3
	} frame_status_t;

	// phase selector value for "no match"
	localparam logic [1:0] PHASE_NONE = 2'd3;

endpackage

@@ rtl/psfr_in_if.sv @@
// Input item channel: valid/ready plus the item fields.
// Depends on psfr_pkg.
interface psfr_in_if;
	import psfr_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic       frame_end;
	logic [1:0] read_phase;
	logic [9:0] read_index;

	modport source (output valid, mode, data_byte, frame_end, read_phase, read_index,
		input ready);
	modport sink (input valid, mode, data_byte, frame_end, read_phase, read_index,
		output ready);
endinterface

@@ rtl/psfr_out_if.sv @@
// Result item channel: valid/ready plus the result fields.
// Depends on psfr_pkg.
interface psfr_out_if;
	import psfr_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [15:0] read_value;
	logic [1:0]         frame_status;
	logic               batch_complete;
	logic               frames_ready;

	modport source (output valid, read_value, frame_status, batch_complete, frames_ready,
		input ready);
	modport sink (input valid, read_value, frame_status, batch_complete, frames_ready,
		output ready);
endinterface

@@ rtl/psfr_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and data.
// Depends on psfr_pkg.
interface psfr_cfg_if;
	import psfr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/phase_sample_frame_reassembler_core.sv @@
// Phase sample frame reassembler: top level with sample stores and result register.
// Depends on psfr_pkg, psfr_in_if, psfr_out_if, psfr_cfg_if and the assertion header.
//
// Usage:
//   samp_in  - one beat per item: a frame byte, a release of the ready flag,
//              or a read of one stored sample.
//   samp_out - exactly one result beat per input beat, in order.
//   cfg      - register writes (phase ids, frames per phase, samples per
//              phase); always ready, write only while no item is in flight.
// Latency: a result is valid the cycle after its input beat is accepted.
// Throughput: one item per cycle when not stalled or sweeping. Each item does its
//   header/data decode and one store access (a write for a low data byte, a read for
//   a read item) in the accepting cycle; store read data lands in the result stage.
// Reset: clears all control state, reloads the register defaults and then
//   sweeps the three sample stores to zero, one entry per store per cycle,
//   over all SAMPLE_DEPTH entries; samp_in.ready stays low during the sweep.
// Stall: when samp_out.ready is low the result register holds; a new beat is
//   still taken into the result register in the cycle it is released.
`include "phase_sample_frame_reassembler_core_assert.svh"

module phase_sample_frame_reassembler_core #(
	parameter int SAMPLE_DEPTH     = psfr_pkg::SAMPLE_DEPTH_DEF,
	parameter int VALUES_PER_FRAME = psfr_pkg::VALUES_PER_FRAME_DEF,
	parameter int MAX_FRAMES       = psfr_pkg::MAX_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	psfr_in_if.sink     samp_in,
	psfr_out_if.source  samp_out,
	psfr_cfg_if.sink    cfg
);
	import psfr_pkg::*;

	localparam int AW   = $clog2(SAMPLE_DEPTH);
	localparam int WIDE = (AW > 10) ? AW : 10;
	localparam logic [6:0] DATA_END = 7'(2 + 2 * VALUES_PER_FRAME);

	// configuration registers
	logic [7:0]  phase_id_first_q, phase_id_second_q, phase_id_third_q;
	logic [5:0]  frames_per_phase_q;
	logic [10:0] samples_per_phase_q;

	// frame tracking state
	logic [6:0]            pos_q, pos_d;
	logic [7:0]            hdr_q, hdr_d;
	logic [4:0]            slot_q, slot_d;
	frame_status_t         verdict_q, verdict_d;
	logic [7:0]            held_q, held_d;
	logic [MAX_FRAMES-1:0] bm_q [3];
	logic [MAX_FRAMES-1:0] bm_d [3];
	logic                  ready_q, ready_d;

	// store clearing sweep
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	// store access
	logic          wr_en;
	logic [1:0]    wr_bank;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data_s1 [3];

	// result stage
	logic          out_valid_q;
	frame_status_t status_s1, status_d;
	logic          done_s1, done_d;
	logic          ready_s1;
	logic          rd_hit_s1, rd_hit_d;
	logic [1:0]    rd_bank_s1;

	logic acc;

	// misc decode
	logic [5:0]            n_frames;
	logic [MAX_FRAMES-1:0] frame_mask;
	logic [MAX_FRAMES-1:0] set_vec;
	logic [1:0]            hdr_sel, new_sel;
	logic [4:0]            new_slot;
	logic [6:0]            data_off;
	logic [5:0]            k_idx;
	logic [9:0]            s_idx;
	logic [WIDE-1:0]       s_idx_w, r_idx_w;
	logic                  batch_full;

	// first matching phase id wins
	function automatic logic [1:0] phase_of(input logic [7:0] id, input logic [7:0] p0,
			input logic [7:0] p1, input logic [7:0] p2);
		logic [1:0] r;
		if (id == p0) r = 2'd0;
		else if (id == p1) r = 2'd1;
		else if (id == p2) r = 2'd2;
		else r = PHASE_NONE;
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign samp_in.ready = !clearing_q && (!out_valid_q || samp_out.ready);
	assign acc = samp_in.valid && samp_in.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_id_first_q    <= 8'd1;
			phase_id_second_q   <= 8'd2;
			phase_id_third_q    <= 8'd3;
			frames_per_phase_q  <= 6'd9;
			samples_per_phase_q <= 11'd256;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_PHASE_ID_FIRST:    phase_id_first_q    <= cfg.data[7:0];
				CFG_PHASE_ID_SECOND:   phase_id_second_q   <= cfg.data[7:0];
				CFG_PHASE_ID_THIRD:    phase_id_third_q    <= cfg.data[7:0];
				CFG_FRAMES_PER_PHASE:  frames_per_phase_q  <= cfg.data[5:0];
				CFG_SAMPLES_PER_PHASE: samples_per_phase_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// active frame count and its bitmap mask
	assign n_frames = (frames_per_phase_q > 6'(MAX_FRAMES)) ? 6'(MAX_FRAMES)
		: frames_per_phase_q;
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			frame_mask[i] = (7'(i) < {1'b0, n_frames});
			set_vec[i]    = (new_slot == 5'(i));
		end
	end

	// phase lookups against current config
	assign hdr_sel  = phase_of(hdr_q, phase_id_first_q, phase_id_second_q, phase_id_third_q);
	assign new_sel  = hdr_sel;
	assign new_slot = 5'(samp_in.data_byte - 8'd1);

	// data word placement
	assign data_off = pos_q - DATA_FIRST;
	assign k_idx    = data_off[6:1];
	assign s_idx    = 10'({5'd0, slot_q} * 10'(VALUES_PER_FRAME)) + 10'(k_idx);
	assign s_idx_w  = WIDE'(s_idx);
	assign r_idx_w  = WIDE'(samp_in.read_index);

	// next state for one accepted item
	always_comb begin
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		slot_d     = slot_q;
		verdict_d  = verdict_q;
		held_d     = held_q;
		bm_d       = bm_q;
		ready_d    = ready_q;
		status_d   = STATUS_NONE;
		done_d     = 1'b0;
		rd_hit_d   = 1'b0;
		wr_en      = 1'b0;
		wr_bank    = hdr_sel;
		wr_addr    = s_idx_w[AW-1:0];
		wr_data    = {held_q, samp_in.data_byte} - SAMPLE_OFFSET;
		rd_en      = 1'b0;
		rd_addr    = r_idx_w[AW-1:0];
		batch_full = 1'b0;
		if (acc) begin
			case (mode_t'(samp_in.mode))
				MODE_FRAME: begin
					if (pos_q == 7'd0) begin
						hdr_d     = samp_in.data_byte;
						verdict_d = STATUS_BAD_NUM;
					end else if (pos_q == 7'd1) begin
						// header: frame number check wins over phase check
						if (samp_in.data_byte == 8'd0 || samp_in.data_byte > {2'b00, n_frames}) begin
							verdict_d = STATUS_BAD_NUM;
						end else if (new_sel == PHASE_NONE) begin
							verdict_d = STATUS_UNKNOWN;
						end else begin
							slot_d    = new_slot;
							verdict_d = STATUS_STORED;
							for (int p = 0; p < 3; p++) begin
								if (new_sel == 2'(p)) bm_d[p] = bm_q[p] | set_vec;
							end
						end
					end else if (pos_q < DATA_END && verdict_q == STATUS_STORED) begin
						// data: even offset holds the high byte, odd offset writes
						if (!data_off[0]) begin
							held_d = samp_in.data_byte;
						end else if (k_idx < 6'(VALUES_PER_FRAME) &&
								{1'b0, s_idx} < samples_per_phase_q &&
								(WIDE + 1)'(s_idx_w) < (WIDE + 1)'(SAMPLE_DEPTH) &&
								hdr_sel != PHASE_NONE) begin
							wr_en = 1'b1;
						end
					end
					if (samp_in.frame_end) begin
						status_d   = verdict_d;
						batch_full = 1'b1;
						for (int p = 0; p < 3; p++) begin
							batch_full = batch_full && ((bm_d[p] & frame_mask) == frame_mask);
						end
						if (!ready_q && batch_full) begin
							ready_d = 1'b1;
							done_d  = 1'b1;
							for (int p = 0; p < 3; p++) bm_d[p] = '0;
						end
						pos_d     = 7'd0;
						verdict_d = STATUS_NONE;
					end else if (pos_q < POS_LIMIT) begin
						pos_d = pos_q + 7'd1;
					end
				end
				MODE_RELEASE: ready_d = 1'b0;
				MODE_READ: begin
					rd_en    = 1'b1;
					rd_hit_d = (samp_in.read_phase != PHASE_NONE) &&
						((WIDE + 1)'(r_idx_w) < (WIDE + 1)'(SAMPLE_DEPTH));
				end
				default: ;
			endcase
		end
	end

	// frame tracking registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_q     <= '0;
			slot_q    <= '0;
			verdict_q <= STATUS_NONE;
			held_q    <= '0;
			ready_q   <= 1'b0;
			for (int p = 0; p < 3; p++) bm_q[p] <= '0;
		end else begin
			pos_q     <= pos_d;
			hdr_q     <= hdr_d;
			slot_q    <= slot_d;
			verdict_q <= verdict_d;
			held_q    <= held_d;
			ready_q   <= ready_d;
			bm_q      <= bm_d;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(SAMPLE_DEPTH - 1)) clearing_q <= 1'b0;
		end
	end

	// one sample store per phase, registered read
	for (genvar b = 0; b < 3; b++) begin : g_bank
		logic [15:0] mem [SAMPLE_DEPTH];

		always_ff @(posedge clk) begin
			if (clearing_q) begin
				mem[clr_idx_q] <= '0;
			end else if (wr_en && wr_bank == 2'(b)) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) rd_data_s1[b] <= mem[rd_addr];
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (samp_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1  <= status_d;
			done_s1    <= done_d;
			ready_s1   <= ready_d;
			rd_hit_s1  <= rd_hit_d;
			rd_bank_s1 <= samp_in.read_phase;
		end
	end

	// result beat
	assign samp_out.valid          = out_valid_q;
	assign samp_out.read_value     = !rd_hit_s1 ? 16'sd0
		: (rd_bank_s1 == 2'd0) ? signed'(rd_data_s1[0])
		: (rd_bank_s1 == 2'd1) ? signed'(rd_data_s1[1])
		: signed'(rd_data_s1[2]);
	assign samp_out.frame_status   = status_s1;
	assign samp_out.batch_complete = done_s1;
	assign samp_out.frames_ready   = ready_s1;

	// checks
	`PSFR_ASSERT_NOW(a_done_sets_ready, clk, arst_n,
		out_valid_q && done_s1, ready_s1)
	`PSFR_ASSERT_NEXT(a_done_clears_maps, clk, arst_n,
		acc && done_d, bm_q[0] == '0 && bm_q[1] == '0 && bm_q[2] == '0)
	`PSFR_ASSERT_NEXT(a_frame_end_rewinds, clk, arst_n,
		acc && samp_in.mode == MODE_FRAME && samp_in.frame_end,
		pos_q == 7'd0 && verdict_q == STATUS_NONE)
	`PSFR_ASSERT_NOW(a_no_result_while_clearing, clk, arst_n,
		clearing_q, !out_valid_q && !wr_en)

endmodule
